// File: rtl/sdso_pkg.sv
// Shared constants, types and angle table for the spiral disc sample offset block.
`timescale 1ns / 1ps

package sdso_pkg;

  // Field and datapath widths
  localparam int IDX_W        = 15;
  localparam int RADIUS_W     = 6;
  localparam int SQ_W         = 48;
  localparam int SQ_STEPS     = 24;
  localparam int QUO_W        = 47;
  localparam int ROOT_W       = 24;
  localparam int TH_W         = 25;
  localparam int RAD_W        = 30;
  localparam int CV_W         = 20;
  localparam int CORDIC_STEPS = 16;
  localparam int MOD_STEPS    = 7;
  localparam int PROD_W       = RAD_W + 1 + CV_W;
  localparam int OFS_W        = 8;

  // Fixed-point constants, 16 fractional bits unless noted
  localparam logic [IDX_W-1:0]       SAMPLE_MAX      = 15'd16384;
  localparam logic [29:0]            TWO_SQRT_PI_Q28 = 30'd951578915;
  localparam logic [TH_W-1:0]        TWO_PI_QF       = 25'd411775;
  localparam logic signed [CV_W-1:0] TWO_PI_S        = 20'sd411775;
  localparam logic signed [CV_W-1:0] PI_QF           = 20'sd205887;
  localparam logic signed [CV_W-1:0] HALF_PI_QF      = 20'sd102943;
  localparam logic signed [CV_W-1:0] GAIN_QF         = 20'sd39797;
  localparam logic [7:0]             OFS_LIMIT       = 8'd127;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_BLUR_RADIUS  = 2'd0,
    REG_DISC_PIXELS  = 2'd1,
    REG_SAMPLE_TOTAL = 2'd2
  } cfg_reg_t;

  // One delivered result
  typedef struct packed {
    logic [OFS_W-1:0] x_offset;
    logic [OFS_W-1:0] y_offset;
    logic             last;
    logic             clipped;
  } out_item_t;

  // Rotation angle atan(2^-step) in QF
  function automatic logic signed [CV_W-1:0] atan_qf(input int step);
    logic signed [CV_W-1:0] a;
    case (step)
      0:       a = 20'sd51472;
      1:       a = 20'sd30386;
      2:       a = 20'sd16055;
      3:       a = 20'sd8150;
      4:       a = 20'sd4091;
      5:       a = 20'sd2047;
      6:       a = 20'sd1024;
      7:       a = 20'sd512;
      8:       a = 20'sd256;
      9:       a = 20'sd128;
      10:      a = 20'sd64;
      default: a = 20'sd1 <<< (16 - step);
    endcase
    return a;
  endfunction

endpackage

// File: rtl/sdso_sqrt_cell.sv
// One bit step of the pipelined integer square root.
`timescale 1ns / 1ps

module sdso_sqrt_cell #(
  parameter int STEP   = 0,
  parameter int SIDE_W = 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_vld,
  input  logic [sdso_pkg::SQ_W-1:0] in_v,
  input  logic [sdso_pkg::SQ_W-1:0] in_res,
  input  logic [SIDE_W-1:0]        in_side,
  output logic                     out_vld,
  output logic [sdso_pkg::SQ_W-1:0] out_v,
  output logic [sdso_pkg::SQ_W-1:0] out_res,
  output logic [SIDE_W-1:0]        out_side
);

  localparam int W = sdso_pkg::SQ_W;
  localparam logic [W-1:0] BIT = W'(1) << (2 * (sdso_pkg::SQ_STEPS - 1 - STEP));

  logic         vld_r;
  logic [W-1:0] v_r, v_nxt, res_r, res_nxt, trial;
  logic [SIDE_W-1:0] side_r;
  logic         take;

  // Try the next root bit
  always_comb begin
    trial   = in_res + BIT;
    take    = (in_v >= trial);
    v_nxt   = take ? (in_v - trial) : in_v;
    res_nxt = take ? ((in_res >> 1) + BIT) : (in_res >> 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_r    <= v_nxt;
      res_r  <= res_nxt;
      side_r <= in_side;
    end
  end

  assign out_vld  = vld_r;
  assign out_v    = v_r;
  assign out_res  = res_r;
  assign out_side = side_r;

endmodule

// File: rtl/sdso_div_cell.sv
// One quotient bit step of the pipelined k/N restoring division.
`timescale 1ns / 1ps

module sdso_div_cell #(
  parameter int IDX    = 0,
  parameter int SIDE_W = 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic [sdso_pkg::IDX_W-1:0]  n,
  input  logic                        in_vld,
  input  logic [sdso_pkg::IDX_W-1:0]  in_k,
  input  logic [sdso_pkg::IDX_W-1:0]  in_rem,
  input  logic [sdso_pkg::QUO_W-1:0]  in_quo,
  input  logic [SIDE_W-1:0]           in_side,
  output logic                        out_vld,
  output logic [sdso_pkg::IDX_W-1:0]  out_k,
  output logic [sdso_pkg::IDX_W-1:0]  out_rem,
  output logic [sdso_pkg::QUO_W-1:0]  out_quo,
  output logic [SIDE_W-1:0]           out_side
);

  localparam int KW = sdso_pkg::IDX_W;
  localparam int QW = sdso_pkg::QUO_W;
  localparam int KB = (IDX < KW) ? (KW - 1 - IDX) : 0;

  logic          vld_r;
  logic [KW-1:0] k_r, rem_r, rem_nxt, rem_sh;
  logic [QW-1:0] quo_r, quo_nxt;
  logic [SIDE_W-1:0] side_r;
  logic          dbit, take;

  // Bring down the next dividend bit; the low dividend bits are zero
  always_comb begin
    dbit    = (IDX < KW) ? in_k[KB] : 1'b0;
    rem_sh  = {in_rem[KW-2:0], dbit};
    take    = (rem_sh >= n);
    rem_nxt = take ? (rem_sh - n) : rem_sh;
    quo_nxt = {in_quo[QW-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k_r    <= in_k;
      rem_r  <= rem_nxt;
      quo_r  <= quo_nxt;
      side_r <= in_side;
    end
  end

  assign out_vld  = vld_r;
  assign out_k    = k_r;
  assign out_rem  = rem_r;
  assign out_quo  = quo_r;
  assign out_side = side_r;

endmodule

// File: rtl/sdso_cordic_cell.sv
// One rotation step of the pipelined CORDIC.
`timescale 1ns / 1ps

module sdso_cordic_cell #(
  parameter int STEP   = 0,
  parameter int SIDE_W = 1
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               in_vld,
  input  logic signed [sdso_pkg::CV_W-1:0]   in_x,
  input  logic signed [sdso_pkg::CV_W-1:0]   in_y,
  input  logic signed [sdso_pkg::CV_W-1:0]   in_z,
  input  logic [SIDE_W-1:0]                  in_side,
  output logic                               out_vld,
  output logic signed [sdso_pkg::CV_W-1:0]   out_x,
  output logic signed [sdso_pkg::CV_W-1:0]   out_y,
  output logic signed [sdso_pkg::CV_W-1:0]   out_z,
  output logic [SIDE_W-1:0]                  out_side
);

  localparam int W = sdso_pkg::CV_W;
  localparam logic signed [W-1:0] ANG = sdso_pkg::atan_qf(STEP);

  logic                vld_r;
  logic signed [W-1:0] x_r, y_r, z_r, x_nxt, y_nxt, z_nxt, dx, dy;
  logic [SIDE_W-1:0]   side_r;

  // Rotate toward zero residual angle
  always_comb begin
    dx = in_y >>> STEP;
    dy = in_x >>> STEP;
    if (!in_z[W-1]) begin
      x_nxt = in_x - dx;
      y_nxt = in_y + dy;
      z_nxt = in_z - ANG;
    end else begin
      x_nxt = in_x + dx;
      y_nxt = in_y - dy;
      z_nxt = in_z + ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      side_r <= in_side;
    end
  end

  assign out_vld  = vld_r;
  assign out_x    = x_r;
  assign out_y    = y_r;
  assign out_z    = z_r;
  assign out_side = side_r;

endmodule

// File: rtl/spiral_disc_sample_offsets.sv
// Top level: pipelined spiral disc sample offset generator.
//
//   channel | direction | payload                                           | handshake
//   in      | input     | in_sample_index                                   | in_valid / in_ready
//   out     | output    | out_x_offset, out_y_offset, out_last, out_clipped | out_valid / out_ready
//   cfg     | input     | cfg_index, cfg_data                               | cfg_valid / cfg_ready
//
// One request per cycle is taken while the chain advances; a request passes
// through a chain of 24 root cells, 47 divide cells, 24 root cells, 7 modulo
// cells, 16 CORDIC cells and five single stages. Reset clears all valid bits.
// The whole chain advances while the two-entry output buffer has room or is
// being drained, so one result may wait while new requests still enter.
`timescale 1ns / 1ps

module spiral_disc_sample_offsets (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [14:0] in_sample_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_x_offset,
  output logic [7:0]  out_y_offset,
  output logic        out_last,
  output logic        out_clipped,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [14:0] cfg_data
);

  localparam int KW  = sdso_pkg::IDX_W;
  localparam int SW  = sdso_pkg::SQ_W;
  localparam int NSQ = sdso_pkg::SQ_STEPS;
  localparam int QW  = sdso_pkg::QUO_W;
  localparam int RW  = sdso_pkg::ROOT_W;
  localparam int TW  = sdso_pkg::TH_W;
  localparam int AW  = sdso_pkg::RAD_W;
  localparam int CW  = sdso_pkg::CV_W;
  localparam int NCD = sdso_pkg::CORDIC_STEPS;
  localparam int NMD = sdso_pkg::MOD_STEPS;
  localparam int PW  = sdso_pkg::PROD_W;
  localparam int S1W = KW + 1;
  localparam int S2W = RW + 1;
  localparam int MDW = AW + 1;
  localparam int CDW = AW + 2;

  // Rounded offset from a QF*QF product, saturated to the offset range
  function automatic logic [8:0] ofs_of(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] v;
    logic [PW-1:0]        mag;
    logic [PW-33:0]       mq;
    logic [7:0]           o;
    logic                 clip;
    v    = p + (PW'(1) <<< 31);
    mag  = v[PW-1] ? PW'(-v) : PW'(v);
    mq   = mag[PW-1:32];
    clip = (mq > (PW-32)'(sdso_pkg::OFS_LIMIT));
    o    = clip ? sdso_pkg::OFS_LIMIT : mq[7:0];
    return {clip, v[PW-1] ? 8'(-o) : o};
  endfunction

  logic                 en;
  logic [5:0]           blur_r;
  logic [KW-1:0]        dpc_r, total_r, n_eff;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blur_r  <= '0;
      dpc_r   <= KW'(1);
      total_r <= KW'(1);
    end else if (cfg_valid) begin
      unique case (sdso_pkg::cfg_reg_t'(cfg_index))
        sdso_pkg::REG_BLUR_RADIUS:  blur_r  <= cfg_data[5:0];
        sdso_pkg::REG_DISC_PIXELS:  dpc_r   <= cfg_data;
        sdso_pkg::REG_SAMPLE_TOTAL: total_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp the pixel count to 1..max
  always_comb begin
    if (dpc_r > sdso_pkg::SAMPLE_MAX) begin
      n_eff = sdso_pkg::SAMPLE_MAX;
    end else if (dpc_r == '0) begin
      n_eff = KW'(1);
    end else begin
      n_eff = dpc_r;
    end
  end

  // Capture stage: clamp the index, flag the last sample
  logic          cap_vld_r, cap_last_r;
  logic [KW-1:0] cap_k_r;

  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_vld_r <= 1'b0;
    end else if (en) begin
      cap_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cap_k_r    <= (in_sample_index > sdso_pkg::SAMPLE_MAX) ? sdso_pkg::SAMPLE_MAX
                                                             : in_sample_index;
      cap_last_r <= (in_sample_index == total_r);
    end
  end

  // Root of k scaled by 2^32
  logic          s1_vld  [0:NSQ];
  logic [SW-1:0] s1_v    [0:NSQ];
  logic [SW-1:0] s1_res  [0:NSQ];
  logic [S1W-1:0] s1_side [0:NSQ];

  assign s1_vld[0]  = cap_vld_r;
  assign s1_v[0]    = {1'b0, cap_k_r, 32'd0};
  assign s1_res[0]  = '0;
  assign s1_side[0] = {cap_last_r, cap_k_r};

  for (genvar i = 0; i < NSQ; i++) begin : g_sq1
    sdso_sqrt_cell #(.STEP(i), .SIDE_W(S1W)) u_cell (
      .clk, .rst_n, .en,
      .in_vld(s1_vld[i]), .in_v(s1_v[i]), .in_res(s1_res[i]), .in_side(s1_side[i]),
      .out_vld(s1_vld[i+1]), .out_v(s1_v[i+1]), .out_res(s1_res[i+1]),
      .out_side(s1_side[i+1])
    );
  end

  // Ratio k/N in Q32
  logic          dv_vld  [0:QW];
  logic [KW-1:0] dv_k    [0:QW];
  logic [KW-1:0] dv_rem  [0:QW];
  logic [QW-1:0] dv_quo  [0:QW];
  logic [S2W-1:0] dv_side [0:QW];

  assign dv_vld[0]  = s1_vld[NSQ];
  assign dv_k[0]    = s1_side[NSQ][KW-1:0];
  assign dv_rem[0]  = '0;
  assign dv_quo[0]  = '0;
  assign dv_side[0] = {s1_side[NSQ][KW], s1_res[NSQ][RW-1:0]};

  for (genvar i = 0; i < QW; i++) begin : g_div
    sdso_div_cell #(.IDX(i), .SIDE_W(S2W)) u_cell (
      .clk, .rst_n, .en, .n(n_eff),
      .in_vld(dv_vld[i]), .in_k(dv_k[i]), .in_rem(dv_rem[i]), .in_quo(dv_quo[i]),
      .in_side(dv_side[i]),
      .out_vld(dv_vld[i+1]), .out_k(dv_k[i+1]), .out_rem(dv_rem[i+1]),
      .out_quo(dv_quo[i+1]), .out_side(dv_side[i+1])
    );
  end

  // Root of the ratio
  logic          s2_vld  [0:NSQ];
  logic [SW-1:0] s2_v    [0:NSQ];
  logic [SW-1:0] s2_res  [0:NSQ];
  logic [S2W-1:0] s2_side [0:NSQ];

  assign s2_vld[0]  = dv_vld[QW];
  assign s2_v[0]    = {1'b0, dv_quo[QW]};
  assign s2_res[0]  = '0;
  assign s2_side[0] = dv_side[QW];

  for (genvar i = 0; i < NSQ; i++) begin : g_sq2
    sdso_sqrt_cell #(.STEP(i), .SIDE_W(S2W)) u_cell (
      .clk, .rst_n, .en,
      .in_vld(s2_vld[i]), .in_v(s2_v[i]), .in_res(s2_res[i]), .in_side(s2_side[i]),
      .out_vld(s2_vld[i+1]), .out_v(s2_v[i+1]), .out_res(s2_res[i+1]),
      .out_side(s2_side[i+1])
    );
  end

  // Angle and radius products
  logic          pa_vld_r, pa_last_r;
  logic [TW-1:0] pa_th_r;
  logic [AW-1:0] pa_r_r;
  logic [53:0]   th_prod;

  assign th_prod = 54'(s2_side[NSQ][RW-1:0]) * 54'(sdso_pkg::TWO_SQRT_PI_Q28)
                 + (54'd1 << 27);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pa_vld_r <= 1'b0;
    end else if (en) begin
      pa_vld_r <= s2_vld[NSQ];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa_th_r   <= th_prod[TW+27:28];
      pa_r_r    <= AW'(blur_r) * AW'(s2_res[NSQ][RW-1:0]);
      pa_last_r <= s2_side[NSQ][RW];
    end
  end

  // Reduce the angle modulo 2*pi; each cell subtracts 2*pi times a descending power of two
  logic           md_vld_r  [1:NMD];
  logic [TW-1:0]  md_th_r   [1:NMD];
  logic [MDW-1:0] md_side_r [1:NMD];

  for (genvar i = 0; i < NMD; i++) begin : g_mod
    localparam logic [TW-1:0] DIV = sdso_pkg::TWO_PI_QF << (NMD - 1 - i);
    logic           vld_in;
    logic [TW-1:0]  th_in;
    logic [MDW-1:0] side_in;

    // Take the stage input from the product stage or the previous cell
    if (i == 0) begin : g_head
      assign vld_in  = pa_vld_r;
      assign th_in   = pa_th_r;
      assign side_in = {pa_last_r, pa_r_r};
    end else begin : g_link
      assign vld_in  = md_vld_r[i];
      assign th_in   = md_th_r[i];
      assign side_in = md_side_r[i];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        md_vld_r[i+1] <= 1'b0;
      end else if (en) begin
        md_vld_r[i+1] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        md_th_r[i+1]   <= (th_in >= DIV) ? (th_in - DIV) : th_in;
        md_side_r[i+1] <= side_in;
      end
    end
  end

  // Fold the angle into the right half plane
  logic                 rd_vld_r;
  logic signed [CW-1:0] rd_z_r, z0, z1, rd_z_nxt;
  logic [CDW-1:0]       rd_side_r;
  logic                 rd_neg_nxt;

  always_comb begin
    z0 = CW'(md_th_r[NMD]);
    z1 = (z0 > sdso_pkg::PI_QF) ? (z0 - sdso_pkg::TWO_PI_S) : z0;
    rd_neg_nxt = 1'b0;
    rd_z_nxt   = z1;
    if (z1 > sdso_pkg::HALF_PI_QF) begin
      rd_z_nxt   = z1 - sdso_pkg::PI_QF;
      rd_neg_nxt = 1'b1;
    end else if (z1 < -sdso_pkg::HALF_PI_QF) begin
      rd_z_nxt   = z1 + sdso_pkg::PI_QF;
      rd_neg_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else if (en) begin
      rd_vld_r <= md_vld_r[NMD];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rd_z_r    <= rd_z_nxt;
      rd_side_r <= {md_side_r[NMD][AW], rd_neg_nxt, md_side_r[NMD][AW-1:0]};
    end
  end

  // CORDIC chain
  logic                 cd_vld  [0:NCD];
  logic signed [CW-1:0] cd_x    [0:NCD];
  logic signed [CW-1:0] cd_y    [0:NCD];
  logic signed [CW-1:0] cd_z    [0:NCD];
  logic [CDW-1:0]       cd_side [0:NCD];

  assign cd_vld[0]  = rd_vld_r;
  assign cd_x[0]    = sdso_pkg::GAIN_QF;
  assign cd_y[0]    = '0;
  assign cd_z[0]    = rd_z_r;
  assign cd_side[0] = rd_side_r;

  for (genvar i = 0; i < NCD; i++) begin : g_cordic
    sdso_cordic_cell #(.STEP(i), .SIDE_W(CDW)) u_cell (
      .clk, .rst_n, .en,
      .in_vld(cd_vld[i]), .in_x(cd_x[i]), .in_y(cd_y[i]), .in_z(cd_z[i]),
      .in_side(cd_side[i]),
      .out_vld(cd_vld[i+1]), .out_x(cd_x[i+1]), .out_y(cd_y[i+1]), .out_z(cd_z[i+1]),
      .out_side(cd_side[i+1])
    );
  end

  // Scale cosine and sine by the radius
  logic                 pm_vld_r, pm_last_r;
  logic signed [PW-1:0] pm_x_r, pm_y_r;
  logic signed [CW-1:0] xs, ys;
  logic signed [AW:0]   rs;

  always_comb begin
    xs = cd_side[NCD][AW] ? -cd_x[NCD] : cd_x[NCD];
    ys = cd_side[NCD][AW] ? -cd_y[NCD] : cd_y[NCD];
    rs = $signed({1'b0, cd_side[NCD][AW-1:0]});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pm_vld_r <= 1'b0;
    end else if (en) begin
      pm_vld_r <= cd_vld[NCD];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pm_x_r    <= rs * xs;
      pm_y_r    <= rs * ys;
      pm_last_r <= cd_side[NCD][AW+1];
    end
  end

  // Round and saturate into the output buffer
  sdso_pkg::out_item_t ob_r [0:1];
  sdso_pkg::out_item_t push_item;
  logic [8:0]          xo, yo;
  logic                wr_ptr_r, rd_ptr_r, push, pop;
  logic [1:0]          cnt_r;

  always_comb begin
    xo = ofs_of(pm_x_r);
    yo = ofs_of(pm_y_r);
    push_item.x_offset = xo[7:0];
    push_item.y_offset = yo[7:0];
    push_item.last     = pm_last_r;
    push_item.clipped  = xo[8] | yo[8];
  end

  assign en   = (cnt_r != 2'd2) || out_ready;
  assign push = en && pm_vld_r;
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ob_r[wr_ptr_r] <= push_item;
    end
  end

  assign out_valid    = (cnt_r != 2'd0);
  assign out_x_offset = ob_r[rd_ptr_r].x_offset;
  assign out_y_offset = ob_r[rd_ptr_r].y_offset;
  assign out_last     = ob_r[rd_ptr_r].last;
  assign out_clipped  = ob_r[rd_ptr_r].clipped;

endmodule

// File: rtl/sdso_checker.sv
// Port-level checks for the spiral disc sample offset block, bound to the top level.
`timescale 1ns / 1ps

module sdso_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [14:0] in_sample_index,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_x_offset,
  input logic [7:0]  out_y_offset,
  input logic        out_last,
  input logic        out_clipped,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [1:0]  cfg_index,
  input logic [14:0] cfg_data
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_x_offset) && $stable(out_y_offset)
                                && $stable(out_last) && $stable(out_clipped))
    else $error("stalled result changed");

  // Reset empties the output buffer
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

  // Saturation never yields the most negative code
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_x_offset != 8'h80) && (out_y_offset != 8'h80))
    else $error("offset out of range");

  // Configuration writes are never stalled
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

endmodule

bind spiral_disc_sample_offsets sdso_checker u_sdso_checker (.*);
